// ----- rtl/lfu_pkg.sv -----
// lfu_pkg: shared types and constants for the lfu cache
// used by lfu_cell and lfu_cache; no dependencies
package lfu_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OCC_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 32;
   localparam int STAMP_W = 64;
   localparam int CAP_W   = 5;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   // scan record handed from cell to cell
   typedef struct packed {
      logic                 active;
      logic [DATA_W-1:0]    key;
      logic                 hit;
      idx_type              hit_idx;
      logic [DATA_W-1:0]    hit_value;
      logic                 free_found;
      idx_type              free_idx;
      logic                 vic_found;
      idx_type              vic_idx;
      logic [COUNT_W-1:0]   vic_count;
      logic [STAMP_W-1:0]   vic_stamp;
   } scan_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_TOUCH,
      WR_UPDATE,
      WR_INSERT
   } wr_op_type;

   // write broadcast to all cells
   typedef struct packed {
      wr_op_type            op;
      idx_type              idx;
      logic [DATA_W-1:0]    key;
      logic [DATA_W-1:0]    value;
      logic [STAMP_W-1:0]   stamp;
   } wr_type;

endpackage

// ----- rtl/lfu_cell.sv -----
// lfu_cell: one cache entry plus one stage of the scan chain
// depends on lfu_pkg
module lfu_cell (
   input  logic             clock,
   input  logic             reset,
   input  lfu_pkg::idx_type cell_idx,
   input  lfu_pkg::scan_type scan_prev,
   input  lfu_pkg::wr_type  wr,
   output lfu_pkg::scan_type scan_out
);

   logic                       valid_ff, valid_in;
   logic [lfu_pkg::DATA_W-1:0] key_ff, key_in;
   logic [lfu_pkg::DATA_W-1:0] value_ff, value_in;
   logic [lfu_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [lfu_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   lfu_pkg::scan_type          scan_ff, scan_in;
   logic                       sel;

   assign sel = (wr.idx == cell_idx);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      stamp_in = stamp_ff;
      if (sel) begin
         unique case (wr.op)
            lfu_pkg::WR_NONE: ;
            lfu_pkg::WR_TOUCH, lfu_pkg::WR_UPDATE: begin
               if (count_ff != '1) count_in = count_ff + 1'b1;
               stamp_in = wr.stamp;
               if (wr.op == lfu_pkg::WR_UPDATE) value_in = wr.value;
            end
            lfu_pkg::WR_INSERT: begin
               valid_in = 1'b1;
               key_in   = wr.key;
               value_in = wr.value;
               count_in = lfu_pkg::COUNT_W'(1);
               stamp_in = wr.stamp;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      scan_in = scan_prev;
      if (valid_ff) begin
         if (!scan_prev.hit && key_ff == scan_prev.key) begin
            scan_in.hit       = 1'b1;
            scan_in.hit_idx   = cell_idx;
            scan_in.hit_value = value_ff;
         end
         if (!scan_prev.vic_found || count_ff < scan_prev.vic_count ||
             (count_ff == scan_prev.vic_count && stamp_ff < scan_prev.vic_stamp)) begin
            scan_in.vic_found = 1'b1;
            scan_in.vic_idx   = cell_idx;
            scan_in.vic_count = count_ff;
            scan_in.vic_stamp = stamp_ff;
         end
      end else if (!scan_prev.free_found) begin
         scan_in.free_found = 1'b1;
         scan_in.free_idx   = cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         scan_ff.active <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         scan_ff.active <= scan_in.active;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      stamp_ff <= stamp_in;
      scan_ff.key        <= scan_in.key;
      scan_ff.hit        <= scan_in.hit;
      scan_ff.hit_idx    <= scan_in.hit_idx;
      scan_ff.hit_value  <= scan_in.hit_value;
      scan_ff.free_found <= scan_in.free_found;
      scan_ff.free_idx   <= scan_in.free_idx;
      scan_ff.vic_found  <= scan_in.vic_found;
      scan_ff.vic_idx    <= scan_in.vic_idx;
      scan_ff.vic_count  <= scan_in.vic_count;
      scan_ff.vic_stamp  <= scan_in.vic_stamp;
   end

   assign scan_out = scan_ff;

endmodule

// ----- rtl/lfu_cache.sv -----
// lfu_cache: top level; sequencer, capacity register and row of lfu_cell
// depends on lfu_pkg and lfu_cell
// the result strobe is registered once the scan record leaves the last cell
// a new transaction is accepted only once the previous one has left the row of cells;
//   the scan record walks the row of cells one cell per cycle
// reset: cache empty, capacity 16; the receiver cannot stall results
module lfu_cache (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_command,
   input  logic [lfu_pkg::DATA_W-1:0]  req_key,
   input  logic [lfu_pkg::DATA_W-1:0]  req_value,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0]   csr_wr_data,
   output logic                        rsp_valid,
   output logic                        rsp_found,
   output logic [lfu_pkg::DATA_W-1:0]  rsp_read_value
);

   logic [lfu_pkg::CAP_W-1:0]   cap_ff;
   logic [lfu_pkg::OCC_W-1:0]   occ_ff, occ_in;
   logic [lfu_pkg::STAMP_W-1:0] tick_ff, tick_in;
   logic                        busy_ff, busy_in;
   logic                        cmd_ff;
   logic [lfu_pkg::DATA_W-1:0]  val_ff;
   lfu_pkg::scan_type           inj_ff, inj_in;
   lfu_pkg::wr_type             wr_ff, wr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [lfu_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   lfu_pkg::scan_type           chain [lfu_pkg::DEPTH];
   lfu_pkg::scan_type           last;
   logic                        accept;

   assign accept = start && !busy_ff;
   assign last   = chain[lfu_pkg::DEPTH-1];

   genvar g;
   generate
      for (g = 0; g < lfu_pkg::DEPTH; g++) begin : g_cell
         lfu_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_idx  (lfu_pkg::IDX_W'(g)),
            .scan_prev ((g == 0) ? inj_ff : chain[(g == 0) ? 0 : g-1]),
            .wr        (wr_ff),
            .scan_out  (chain[g])
         );
      end
   endgenerate

   always_comb begin
      inj_in            = '0;
      inj_in.active     = accept;
      inj_in.key        = req_key;
   end

   // decide once the record leaves the last cell
   always_comb begin
      wr_in        = '0;
      wr_in.op     = lfu_pkg::WR_NONE;
      wr_in.key    = last.key;
      wr_in.value  = val_ff;
      wr_in.stamp  = tick_ff;
      occ_in       = occ_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = 1'b0;
      rsp_value_in = '0;
      busy_in      = busy_ff;
      if (accept) busy_in = 1'b1;
      if (last.active) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_found_in = last.hit;
         if (cmd_ff == lfu_pkg::CMD_GET) begin
            if (last.hit) begin
               rsp_value_in = last.hit_value;
               wr_in.op     = lfu_pkg::WR_TOUCH;
               wr_in.idx    = last.hit_idx;
            end else begin
               rsp_value_in = '1;
            end
         end else if (cap_ff != '0) begin
            if (last.hit) begin
               wr_in.op  = lfu_pkg::WR_UPDATE;
               wr_in.idx = last.hit_idx;
            end else if (32'(occ_ff) < 32'(cap_ff) && last.free_found) begin
               wr_in.op  = lfu_pkg::WR_INSERT;
               wr_in.idx = last.free_idx;
               occ_in    = occ_ff + 1'b1;
            end else if (last.vic_found) begin
               wr_in.op  = lfu_pkg::WR_INSERT;
               wr_in.idx = last.vic_idx;
            end
         end
      end
   end

   assign tick_in = (wr_in.op != lfu_pkg::WR_NONE) ? tick_ff + 1'b1 : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= lfu_pkg::CAP_W'(16);
         occ_ff       <= '0;
         tick_ff      <= '0;
         busy_ff      <= 1'b0;
         inj_ff       <= '0;
         wr_ff.op     <= lfu_pkg::WR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         occ_ff       <= occ_in;
         tick_ff      <= tick_in;
         busy_ff      <= busy_in;
         inj_ff       <= inj_in;
         wr_ff.op     <= wr_in.op;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
      end
      wr_ff.idx    <= wr_in.idx;
      wr_ff.key    <= wr_in.key;
      wr_ff.value  <= wr_in.value;
      wr_ff.stamp  <= wr_in.stamp;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

endmodule

// ----- tb/lfu_cache_checker.sv -----
// lfu_cache_checker: watches the lfu_cache transaction and result ports,
// predicts each result with its own cache model and compares; needs lfu_pkg
`timescale 1ns / 100ps
module lfu_cache_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic                        req_command,
   input  logic [lfu_pkg::DATA_W-1:0]  req_key,
   input  logic [lfu_pkg::DATA_W-1:0]  req_value,
   input  logic                        csr_wr_en,
   input  logic [lfu_pkg::CAP_W-1:0]   csr_wr_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_found,
   input  logic [lfu_pkg::DATA_W-1:0]  rsp_read_value,
   output int                          fail_count,
   output int                          pending_count,
   output int                          hit_count
);
   import lfu_pkg::*;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] read_value;
   } lookup_result_type;

   lookup_result_type  expected_results[$];
   logic [CAP_W-1:0]   cap_reg;
   logic               slot_valid [DEPTH];
   logic [DATA_W-1:0]  slot_key   [DEPTH];
   logic [DATA_W-1:0]  slot_value [DEPTH];
   logic [COUNT_W-1:0] slot_uses  [DEPTH];
   logic [STAMP_W-1:0] slot_stamp [DEPTH];
   int                 fill_level;
   logic [STAMP_W-1:0] stamp_now;

   task automatic report_mismatch(input string msg);
      $display("lfu_cache_checker: %0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic bump_slot(input int s);
      if (slot_uses[s] != '1) slot_uses[s]++;
      slot_stamp[s] = stamp_now;
      stamp_now++;
   endtask

   function automatic int oldest_rarest();
      int pick;
      pick = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (!slot_valid[i]) continue;
         if (pick < 0 || slot_uses[i] < slot_uses[pick] ||
             (slot_uses[i] == slot_uses[pick] && slot_stamp[i] < slot_stamp[pick]))
            pick = i;
      end
      return pick;
   endfunction

   task automatic predict_lookup(input logic cmd, input logic [DATA_W-1:0] k,
                                 input logic [DATA_W-1:0] v);
      lookup_result_type r;
      int hit_slot, slot, cap;
      hit_slot = -1;
      slot = -1;
      cap = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
      for (int i = 0; i < DEPTH; i++)
         if (hit_slot < 0 && slot_valid[i] && slot_key[i] == k) hit_slot = i;
      r.found = (hit_slot >= 0);
      r.read_value = '0;
      if (hit_slot >= 0) hit_count++;
      if (cmd == CMD_GET) begin
         if (hit_slot >= 0) begin
            r.read_value = slot_value[hit_slot];
            bump_slot(hit_slot);
         end else
            r.read_value = '1;
      end else if (cap != 0) begin
         if (hit_slot >= 0) begin
            slot_value[hit_slot] = v;
            bump_slot(hit_slot);
         end else begin
            if (fill_level < cap)
               for (int i = 0; i < DEPTH; i++)
                  if (slot < 0 && !slot_valid[i]) slot = i;
            if (slot < 0) begin
               slot = oldest_rarest();
               if (slot >= 0) begin
                  slot_valid[slot] = 1'b0;
                  if (fill_level > 0) fill_level--;
               end
            end
            if (slot >= 0) begin
               slot_valid[slot] = 1'b1;
               slot_key[slot]   = k;
               slot_value[slot] = v;
               slot_uses[slot]  = COUNT_W'(1);
               slot_stamp[slot] = stamp_now;
               stamp_now++;
               fill_level++;
            end
         end
      end
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cap_reg <= 5'd16;
         for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
         fill_level = 0;
         stamp_now = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0)
               report_mismatch("result with no transaction outstanding");
            else begin
               lookup_result_type e;
               e = expected_results.pop_front();
               if (rsp_found !== e.found)
                  report_mismatch($sformatf("found %b, want %b", rsp_found, e.found));
               if (rsp_read_value !== e.read_value)
                  report_mismatch($sformatf("read_value %h, want %h",
                                            rsp_read_value, e.read_value));
            end
         end
         if (start && !busy) predict_lookup(req_command, req_key, req_value);
         if (csr_wr_en) cap_reg <= csr_wr_data;
      end
      pending_count = expected_results.size();
   end

   initial begin
      fail_count = 0;
      hit_count = 0;
      pending_count = 0;
   end
endmodule

// ----- tb/lfu_cache_tb.sv -----
// lfu_cache_tb: top of the lfu_cache testbench; drives transactions and capacity
// writes, gives the verdict; needs lfu_pkg, lfu_cache and lfu_cache_checker
`timescale 1ns / 100ps
module lfu_cache_tb;
   import lfu_pkg::*;

   logic              clock, reset, start, busy;
   logic              req_command;
   logic [DATA_W-1:0] req_key, req_value;
   logic              csr_wr_en;
   logic [CAP_W-1:0]  csr_wr_data;
   logic              rsp_valid, rsp_found;
   logic [DATA_W-1:0] rsp_read_value;
   int                fail_count, pending_count, hit_count;
   int                sent_count;
   logic [DATA_W-1:0] key_pool [8];

   lfu_cache DUT (.*);
   lfu_cache_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("lfu_cache_tb: timeout");
      $display("lfu_cache_tb: done, errors");
      $finish;
   end

   // one transaction, then drop start unless the caller keeps going
   task automatic issue_op(input logic cmd, input logic [DATA_W-1:0] k,
                           input logic [DATA_W-1:0] v, input bit hold);
      start       <= 1'b1;
      req_command <= cmd;
      req_key     <= k;
      req_value   <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
      if (!hold) start <= 1'b0;
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] c);
      while (pending_count != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] pick_key();
      // mostly a small pool so hits and evictions happen, sometimes anything
      if ($urandom_range(0, 9) == 0) return $urandom;
      return key_pool[$urandom_range(0, 7)];
   endfunction

   task automatic random_phase(input int n_ops);
      int burst;
      while (n_ops > 0) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && n_ops > 0; i++, n_ops--)
            issue_op(1'($urandom_range(0, 1)), pick_key(), $urandom,
                     (i < burst - 1) && (n_ops > 1));
         start <= 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   initial begin
      logic [CAP_W-1:0] cap_plan [8];
      cap_plan    = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd16};
      sent_count  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = CMD_GET;
      req_key     = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, miss, hit, update, fill and evict with ties
      issue_op(CMD_GET, 32'h0, 32'h0, 1'b0);
      issue_op(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      issue_op(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      issue_op(CMD_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      issue_op(CMD_GET, 32'h8000_0000, 32'h0, 1'b1);
      issue_op(CMD_PUT, 32'h7FFF_FFFF, 32'h0, 1'b0);
      issue_op(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 17; i++) issue_op(CMD_PUT, 32'h100 + i, i, i != 16);
      write_capacity(5'd2);
      issue_op(CMD_PUT, 32'h55, 32'h1, 1'b0);
      issue_op(CMD_GET, 32'hFFFF_FFFF, 32'h0, 1'b0);
      write_capacity(5'd0);
      issue_op(CMD_PUT, 32'h55, 32'h2, 1'b0);
      issue_op(CMD_PUT, 32'h66, 32'h3, 1'b0);
      issue_op(CMD_GET, 32'h55, 32'h0, 1'b0);

      for (int p = 0; p < 8; p++) begin
         write_capacity(cap_plan[p]);
         random_phase(135);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      $display("lfu_cache_tb: %0d transactions, %0d hits, capacity swept 0 to 31",
               sent_count, hit_count);
      if (fail_count == 0)
         $display("lfu_cache_tb: done, clean");
      else
         $display("lfu_cache_tb: done, errors");
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache.sv
tb/lfu_cache_checker.sv
tb/lfu_cache_tb.sv
